// File: src/shle_pkg.sv
// Signal history log encoder: shared types, codes and record helpers.
// Used by every module of the block; the channel interfaces do not use it.
package shle_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] LIMIT_RESET = 8'd100;
    localparam logic [8:0] COUNT_RESET = 9'd10;

    localparam logic REG_LIMIT = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    localparam logic [1:0] FUNC_START   = 2'd0;
    localparam logic [1:0] FUNC_DECLARE = 2'd1;
    localparam logic [1:0] FUNC_FEED    = 2'd2;

    localparam logic [7:0] OP_DECLARE  = 8'h00;
    localparam logic [7:0] OP_SELECT   = 8'h01;
    localparam logic [7:0] OP_ABS_TIME = 8'h02;
    localparam logic [7:0] OP_REL_TIME = 8'h03;
    localparam logic [7:0] OP_VALUE    = 8'h04;
    localparam logic [7:0] SHORT_VALUE = 8'h80;
    localparam logic [7:0] SHORT_TIME  = 8'hC0;
    localparam logic [62:0] VALUE_SHORT_LIMIT = 63'd31;

    localparam int NSEG = 4;
    localparam logic [1:0] SEG_SELECT = 2'd0;
    localparam logic [1:0] SEG_TIME   = 2'd1;
    localparam logic [1:0] SEG_VALUE  = 2'd2;
    localparam logic [1:0] SEG_OPEN   = 2'd3;

    // one record: head byte, then nbytes payload bytes, big-endian
    typedef struct packed {
        logic        en;
        logic        hdr;
        logic [7:0]  bucket;
        logic [7:0]  head;
        logic [3:0]  nbytes;
        logic [63:0] data;
    } t_seg;

    typedef struct packed {
        t_seg [NSEG-1:0] seg;
    } t_cmd;

    // shortest signed length, 1..8 bytes
    function automatic logic [3:0] slen(input logic [63:0] u);
        logic [3:0]  l;
        logic [63:0] hi;
        logic [63:0] ones;
        l = 4'd8;
        for (int k = 7; k >= 1; k--) begin
            hi   = u >> (8 * k - 1);
            ones = {64{1'b1}} >> (8 * k - 1);
            if (hi == '0 || hi == ones) begin
                l = 4'(k);
            end
        end
        return l;
    endfunction

    function automatic t_seg long_seg(input logic [7:0] op, input logic [63:0] u,
                                      input logic hdr, input logic [7:0] bkt);
        t_seg       s;
        logic [3:0] l;
        l        = slen(u);
        s.en     = 1'b1;
        s.hdr    = hdr;
        s.bucket = bkt;
        s.head   = op | {1'b0, 3'(l - 4'd1), 4'b0000};
        s.nbytes = l;
        s.data   = u;
        return s;
    endfunction

    function automatic t_seg short_seg(input logic [7:0] b, input logic [7:0] bkt);
        t_seg s;
        s.en     = 1'b1;
        s.hdr    = 1'b0;
        s.bucket = bkt;
        s.head   = b;
        s.nbytes = 4'd0;
        s.data   = '0;
        return s;
    endfunction

    function automatic logic [3:0] seg_bytes(input t_seg s);
        return s.en ? s.nbytes + 4'd1 : 4'd0;
    endfunction

endpackage

// File: src/shle_if.sv
// Signal history log encoder: input item and output byte channels.
// Standalone; valid/ready handshake, beat taken when both are high.
interface shle_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] signal_id;
    logic [62:0] value;
    logic [39:0] now;

    modport source(output valid, output func, output signal_id, output value,
                   output now, input ready);
    modport sink(input valid, input func, input signal_id, input value,
                 input now, output ready);
endinterface

interface shle_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       to_header;
    logic [7:0] bucket;
    logic       last;

    modport source(output valid, output out_byte, output to_header, output bucket,
                   output last, input ready);
    modport sink(input valid, input out_byte, input to_header, input bucket,
                 input last, output ready);
endinterface

// File: src/signal_history_log_encoder_top.sv
// Signal history log encoder, top level: register port, front end, queue, serializer.
// Depends on shle_pkg, shle_if, shle_front, shle_fifo and shle_back.
//
// Each item turns into a burst of log bytes, one byte per output beat: start
// gives 2 to 7 bytes, declare 2 to 4, feed 1 to 27. The output port moves one
// byte per cycle while the receiver is ready; a func code of 3 is taken and
// produces nothing. The front end takes one item per cycle into its two stages
// and the command queue while it has room, so input keeps flowing while earlier
// bursts drain until the queue fills; items pass stages A and B, the queue and
// the serializer registers. The last byte of each burst carries last. Registers sit
// at 0x0 (bucket_limit) and 0x4 (bucket_count) and may be written only when idle.
module signal_history_log_encoder_top #(
    parameter int QUEUE_DEPTH = shle_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    shle_in_if.sink     i_item,
    shle_out_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] r_limit;
    logic [8:0] r_count;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == shle_pkg::REG_COUNT) ? {23'd0, r_count} : {24'd0, r_limit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= shle_pkg::LIMIT_RESET;
            r_count <= shle_pkg::COUNT_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == shle_pkg::REG_LIMIT) begin
                r_limit <= pwdata[7:0];
            end else begin
                r_count <= pwdata[8:0];
            end
        end
    end

    shle_pkg::t_cmd front_cmd, queue_cmd;
    logic           front_valid, front_ready;
    logic           queue_valid, queue_ready;

    shle_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_limit     (r_limit),
        .i_count     (r_count),
        .o_cmd       (front_cmd),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (front_ready)
    );

    shle_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (front_valid),
        .o_wr_ready (front_ready),
        .i_wr_data  (front_cmd),
        .o_rd_valid (queue_valid),
        .i_rd_ready (queue_ready),
        .o_rd_data  (queue_cmd)
    );

    shle_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .o_cmd_ready (queue_ready),
        .i_cmd       (queue_cmd),
        .o_res       (o_res)
    );

endmodule

// File: src/shle_front.sv
// Front end: takes items, tracks time, signal and bucket state, builds record commands.
// Depends on shle_pkg and shle_in_if.
module shle_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    shle_in_if.sink           i_item,
    input  logic [7:0]        i_limit,
    input  logic [8:0]        i_count,
    output shle_pkg::t_cmd    o_cmd,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready
);

    // stage A: time difference
    logic        r_a_valid;
    logic [1:0]  r_a_func;
    logic [15:0] r_a_id;
    logic [62:0] r_a_val;
    logic [39:0] r_a_now;
    logic [40:0] r_a_dt;
    logic        r_a_dt_nz;
    logic [39:0] r_last_time;

    // stage B: signal and bucket state
    logic [15:0]    r_cur_id,    n_cur_id;
    logic           r_cur_valid, n_cur_valid;
    logic [7:0]     r_bidx,      n_bidx;
    logic [8:0]     r_blen,      n_blen;
    shle_pkg::t_cmd r_cmd,       n_cmd;
    logic           r_cmd_valid;
    logic           emit;

    logic b_ready, a_fire, a_ready, in_take;

    assign b_ready      = !r_cmd_valid || i_cmd_ready;
    assign a_fire       = r_a_valid && b_ready;
    assign a_ready      = !r_a_valid || b_ready;
    assign in_take      = i_item.valid && a_ready;
    assign i_item.ready = a_ready;
    assign o_cmd        = r_cmd;
    assign o_cmd_valid  = r_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_last_time <= '0;
        end else begin
            if (in_take) begin
                r_a_valid <= 1'b1;
                if (i_item.func == shle_pkg::FUNC_START || i_item.func == shle_pkg::FUNC_FEED) begin
                    r_last_time <= i_item.now;
                end
            end else if (a_fire) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_a_func  <= i_item.func;
            r_a_id    <= i_item.signal_id;
            r_a_val   <= i_item.value;
            r_a_now   <= i_item.now;
            r_a_dt    <= {1'b0, i_item.now} - {1'b0, r_last_time};
            r_a_dt_nz <= i_item.now != r_last_time;
        end
    end

    logic        sel_en;
    logic [4:0]  nbytes;
    logic [9:0]  blen_sum;
    logic [8:0]  blen_sat;
    logic [8:0]  nx;
    logic [7:0]  open_idx;

    always_comb begin
        n_cmd       = '0;
        n_cur_id    = r_cur_id;
        n_cur_valid = r_cur_valid;
        n_bidx      = r_bidx;
        n_blen      = r_blen;
        emit        = 1'b0;
        sel_en      = !r_cur_valid || r_a_id != r_cur_id;
        nbytes      = '0;
        blen_sum    = '0;
        blen_sat    = '0;
        nx          = {1'b0, r_bidx} + 9'd1;
        open_idx    = (nx >= i_count) ? 8'd0 : nx[7:0];
        unique case (r_a_func)
            shle_pkg::FUNC_START: begin
                emit = 1'b1;
                n_cmd.seg[shle_pkg::SEG_OPEN] =
                    shle_pkg::long_seg(shle_pkg::OP_ABS_TIME, {24'd0, r_a_now}, 1'b0, 8'd0);
                n_bidx      = 8'd0;
                n_blen      = {5'd0, shle_pkg::seg_bytes(n_cmd.seg[shle_pkg::SEG_OPEN])};
                n_cur_valid = 1'b0;
            end
            shle_pkg::FUNC_DECLARE: begin
                emit = 1'b1;
                n_cmd.seg[shle_pkg::SEG_SELECT] =
                    shle_pkg::long_seg(shle_pkg::OP_DECLARE, {48'd0, r_a_id}, 1'b1, 8'd0);
                n_cur_id    = r_a_id;
                n_cur_valid = 1'b1;
            end
            shle_pkg::FUNC_FEED: begin
                emit = 1'b1;
                if (sel_en) begin
                    n_cmd.seg[shle_pkg::SEG_SELECT] =
                        shle_pkg::long_seg(shle_pkg::OP_SELECT, {48'd0, r_a_id}, 1'b0, r_bidx);
                end
                if (r_a_dt_nz) begin
                    if (r_a_dt[40:6] == '0) begin
                        n_cmd.seg[shle_pkg::SEG_TIME] = shle_pkg::short_seg(
                            shle_pkg::SHORT_TIME | {2'b00, r_a_dt[5:0]}, r_bidx);
                    end else begin
                        n_cmd.seg[shle_pkg::SEG_TIME] = shle_pkg::long_seg(
                            shle_pkg::OP_REL_TIME, {{23{r_a_dt[40]}}, r_a_dt}, 1'b0, r_bidx);
                    end
                end
                if (r_a_val < shle_pkg::VALUE_SHORT_LIMIT) begin
                    n_cmd.seg[shle_pkg::SEG_VALUE] = shle_pkg::short_seg(
                        shle_pkg::SHORT_VALUE | {3'b000, r_a_val[4:0]}, r_bidx);
                end else begin
                    n_cmd.seg[shle_pkg::SEG_VALUE] = shle_pkg::long_seg(
                        shle_pkg::OP_VALUE, {1'b0, r_a_val}, 1'b0, r_bidx);
                end
                nbytes = 5'(shle_pkg::seg_bytes(n_cmd.seg[shle_pkg::SEG_SELECT]))
                       + 5'(shle_pkg::seg_bytes(n_cmd.seg[shle_pkg::SEG_TIME]))
                       + 5'(shle_pkg::seg_bytes(n_cmd.seg[shle_pkg::SEG_VALUE]));
                blen_sum    = {1'b0, r_blen} + {5'd0, nbytes};
                blen_sat    = blen_sum[9] ? 9'd511 : blen_sum[8:0];
                n_cur_id    = r_a_id;
                n_cur_valid = 1'b1;
                n_blen      = blen_sat;
                if (blen_sat >= {1'b0, i_limit}) begin
                    n_cmd.seg[shle_pkg::SEG_OPEN] =
                        shle_pkg::long_seg(shle_pkg::OP_ABS_TIME, {24'd0, r_a_now}, 1'b0, open_idx);
                    n_bidx      = open_idx;
                    n_blen      = {5'd0, shle_pkg::seg_bytes(n_cmd.seg[shle_pkg::SEG_OPEN])};
                    n_cur_valid = 1'b0;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_id    <= '0;
            r_cur_valid <= 1'b0;
            r_bidx      <= '0;
            r_blen      <= '0;
            r_cmd_valid <= 1'b0;
        end else begin
            if (a_fire) begin
                r_cur_id    <= n_cur_id;
                r_cur_valid <= n_cur_valid;
                r_bidx      <= n_bidx;
                r_blen      <= n_blen;
                r_cmd_valid <= emit;
            end else if (i_cmd_ready) begin
                r_cmd_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// File: src/shle_fifo.sv
// Command queue between front end and byte serializer.
// Depends on shle_pkg for the command type.
module shle_fifo #(
    parameter int DEPTH = shle_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_valid,
    output logic           o_wr_ready,
    input  shle_pkg::t_cmd i_wr_data,
    output logic           o_rd_valid,
    input  logic           i_rd_ready,
    output shle_pkg::t_cmd o_rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    shle_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]  r_wptr, r_rptr;
    logic [CW-1:0]  r_cnt;
    logic           wr, rd;

    assign o_wr_ready = r_cnt != CW'(DEPTH);
    assign o_rd_valid = r_cnt != '0;
    assign o_rd_data  = r_mem[r_rptr];
    assign wr         = i_wr_valid && o_wr_ready;
    assign rd         = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (wr) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (rd) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wptr] <= i_wr_data;
        end
    end

endmodule

// File: src/shle_back.sv
// Byte serializer: walks the records of one command and sends one byte per beat.
// Depends on shle_pkg and shle_out_if.
module shle_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    input  shle_pkg::t_cmd i_cmd,
    shle_out_if.source     o_res
);

    logic           r_busy;
    shle_pkg::t_cmd r_cmd;
    logic [1:0]     r_seg;
    logic [3:0]     r_pos;

    logic           r_out_valid;
    logic [7:0]     r_out_byte;
    logic           r_out_hdr;
    logic [7:0]     r_out_bucket;
    logic           r_out_last;

    shle_pkg::t_seg s;
    logic [3:0]     idx;
    logic [7:0]     cur_byte;
    logic           seg_done;
    logic           more;
    logic [1:0]     nxt_seg;
    logic [1:0]     first_seg;
    logic           out_adv;
    logic           step;
    logic           load;

    assign s        = r_cmd.seg[r_seg];
    assign idx      = s.nbytes - r_pos;
    assign cur_byte = (r_pos == 4'd0) ? s.head : 8'(s.data >> {idx[2:0], 3'b000});
    assign seg_done = r_pos == s.nbytes;
    assign out_adv  = !r_out_valid || o_res.ready;
    assign step     = r_busy && out_adv;

    always_comb begin
        more    = 1'b0;
        nxt_seg = r_seg;
        for (int j = shle_pkg::NSEG - 1; j >= 0; j--) begin
            if (2'(j) > r_seg && r_cmd.seg[j].en) begin
                more    = 1'b1;
                nxt_seg = 2'(j);
            end
        end
        first_seg = shle_pkg::SEG_OPEN;
        for (int j = shle_pkg::NSEG - 1; j >= 0; j--) begin
            if (i_cmd.seg[j].en) begin
                first_seg = 2'(j);
            end
        end
    end

    assign o_cmd_ready = !r_busy || (step && seg_done && !more);
    assign load        = i_cmd_valid && o_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (step && seg_done && !more) begin
                r_busy <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_cmd;
            r_seg <= first_seg;
            r_pos <= 4'd0;
        end else if (step) begin
            if (seg_done) begin
                r_seg <= nxt_seg;
                r_pos <= 4'd0;
            end else begin
                r_pos <= r_pos + 4'd1;
            end
        end
        if (step) begin
            r_out_byte   <= cur_byte;
            r_out_hdr    <= s.hdr;
            r_out_bucket <= s.bucket;
            r_out_last   <= seg_done && !more;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.out_byte  = r_out_byte;
    assign o_res.to_header = r_out_hdr;
    assign o_res.bucket    = r_out_bucket;
    assign o_res.last      = r_out_last;

endmodule

// File: tb/sv/testbench.sv
// Testbench for signal_history_log_encoder_top: directed and random items, APB register
// setup, and a byte-by-byte check of the log stream against an in-bench encoder.
// Depends on shle_pkg, shle_if and the encoder RTL.
`timescale 1ns / 100ps

module testbench;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [7:0] data;
        logic       hdr;
        logic [7:0] bucket;
        logic       last;
    } t_log_byte;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    shle_in_if  item_if ();
    shle_out_if res_if ();

    signal_history_log_encoder_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // encoder state as the bench sees it
    logic [7:0]  cfg_limit;
    logic [8:0]  cfg_count;
    logic [15:0] cur_id;
    bit          cur_valid;
    logic [39:0] last_t;
    logic [7:0]  bkt_idx;
    logic [8:0]  bkt_len;
    int          item_bytes;

    t_log_byte   log_bytes_q[$];

    bit          idle_on;
    int          errors;
    int          items_sent;
    int          bytes_checked;
    int          bucket_moves;
    int          watchdog;

    // stimulus state
    logic [39:0] gen_now;
    logic [15:0] id_pool[4];

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic bit flag_error();
        errors++;
        return errors <= 10;
    endfunction

    // shortest two's complement length in bytes, 1..8
    function automatic int payload_len(input logic [63:0] u);
        int     n;
        int     sh;
        longint s;
        for (n = 1; n < 8; n++) begin
            sh = 64 - 8 * n;
            s  = longint'(u << sh) >>> sh;
            if (s == longint'(u)) break;
        end
        return n;
    endfunction

    function automatic void emit_byte(input logic [7:0] data, input bit hdr);
        t_log_byte e;
        e.data   = data;
        e.hdr    = hdr;
        e.bucket = hdr ? 8'd0 : bkt_idx;
        e.last   = 1'b0;
        log_bytes_q.push_back(e);
        item_bytes++;
        if (!hdr && bkt_len != 9'd511) bkt_len++;
    endfunction

    function automatic void emit_record(input logic [7:0] op, input logic [63:0] u,
                                        input bit hdr);
        int n;
        n = payload_len(u);
        emit_byte(op | 8'((n - 1) << 4), hdr);
        for (int k = n - 1; k >= 0; k--) emit_byte(u[8 * k +: 8], hdr);
    endfunction

    function automatic void open_bucket(input logic [39:0] now);
        bkt_len   = '0;
        last_t    = now;
        emit_record(shle_pkg::OP_ABS_TIME, {24'b0, now}, 1'b0);
        cur_valid = 1'b0;
    endfunction

    function automatic void encode_item(input logic [1:0] func, input logic [15:0] id,
                                        input logic [62:0] val, input logic [39:0] now);
        logic [63:0] dt;
        int          nx;
        t_log_byte   e;
        item_bytes = 0;
        case (func)
            shle_pkg::FUNC_START: begin
                bkt_idx = '0;
                open_bucket(now);
            end
            shle_pkg::FUNC_DECLARE: begin
                emit_record(shle_pkg::OP_DECLARE, {48'b0, id}, 1'b1);
                cur_id    = id;
                cur_valid = 1'b1;
            end
            shle_pkg::FUNC_FEED: begin
                if (!cur_valid || id != cur_id) begin
                    cur_id    = id;
                    cur_valid = 1'b1;
                    emit_record(shle_pkg::OP_SELECT, {48'b0, id}, 1'b0);
                end
                if (now != last_t) begin
                    dt     = {24'b0, now} - {24'b0, last_t};
                    last_t = now;
                    if (dt >= 64'd1 && dt <= 64'd63) begin
                        emit_byte(shle_pkg::SHORT_TIME | dt[7:0], 1'b0);
                    end else begin
                        emit_record(shle_pkg::OP_REL_TIME, dt, 1'b0);
                    end
                end
                if (val < shle_pkg::VALUE_SHORT_LIMIT) begin
                    emit_byte(shle_pkg::SHORT_VALUE | val[7:0], 1'b0);
                end else begin
                    emit_record(shle_pkg::OP_VALUE, {1'b0, val}, 1'b0);
                end
                if (bkt_len >= {1'b0, cfg_limit}) begin
                    nx = int'(bkt_idx) + 1;
                    if (nx >= int'(cfg_count)) nx = 0;
                    bkt_idx = 8'(nx);
                    bucket_moves++;
                    open_bucket(now);
                end
            end
            default: ;
        endcase
        if (item_bytes > 0) begin
            e      = log_bytes_q.pop_back();
            e.last = 1'b1;
            log_bytes_q.push_back(e);
        end
    endfunction

    // output side: random stall bursts while idle_on is set
    always begin
        @(posedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            res_if.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        res_if.ready <= 1'b1;
        repeat ($urandom_range(0, 15)) @(posedge i_clk);
    end

    t_log_byte got_b;
    t_log_byte want_b;

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            bytes_checked++;
            got_b = {res_if.out_byte, res_if.to_header, res_if.bucket, res_if.last};
            if (log_bytes_q.size() == 0) begin
                if (flag_error())
                    $display("%0t: unexpected byte %02h hdr %0b bucket %0d last %0b",
                             $time, got_b.data, got_b.hdr, got_b.bucket, got_b.last);
            end else begin
                want_b = log_bytes_q.pop_front();
                if (got_b.data !== want_b.data || got_b.hdr !== want_b.hdr ||
                    got_b.bucket !== want_b.bucket || got_b.last !== want_b.last) begin
                    if (flag_error())
                        $display({"%0t: byte mismatch, expected %02h hdr %0b bucket %0d ",
                                  "last %0b, got %02h hdr %0b bucket %0d last %0b"},
                                 $time, want_b.data, want_b.hdr, want_b.bucket,
                                 want_b.last, got_b.data, got_b.hdr, got_b.bucket,
                                 got_b.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready)) begin
            watchdog <= 0;
        end else begin
            watchdog <= watchdog + 1;
            if (watchdog >= WATCHDOG_CYCLES) begin
                $display("%0t: no beat for %0d cycles, %0d bytes outstanding",
                         $time, WATCHDOG_CYCLES, log_bytes_q.size());
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [1:0] func, input logic [15:0] id,
                             input logic [62:0] val, input logic [39:0] now);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        item_if.valid     <= 1'b1;
        item_if.func      <= func;
        item_if.signal_id <= id;
        item_if.value     <= val;
        item_if.now       <= now;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        items_sent++;
        encode_item(func, id, val, now);
    endtask

    task automatic wait_idle();
        item_if.valid <= 1'b0;
        @(posedge i_clk);
        while (log_bytes_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [8:0] val);
        logic [31:0] wdata;
        logic [31:0] got;
        logic [8:0]  want;
        wdata = $urandom();
        if (idx == shle_pkg::REG_LIMIT) begin
            wdata[7:0] = val[7:0];
            want       = {1'b0, val[7:0]};
        end else begin
            wdata[8:0] = val;
            want       = val;
        end
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == shle_pkg::REG_LIMIT) cfg_limit = want[7:0];
        else cfg_count = want;
        // readback
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if ((idx == shle_pkg::REG_LIMIT ? {1'b0, got[7:0]} : got[8:0]) !== want) begin
            if (flag_error())
                $display("%0t: register %0d reads %h, expected %h", $time, idx, got, want);
        end
    endtask

    task automatic set_registers(input logic [7:0] limit, input logic [8:0] count);
        wait_idle();
        write_register(shle_pkg::REG_LIMIT, {1'b0, limit});
        write_register(shle_pkg::REG_COUNT, count);
    endtask

    function automatic logic [62:0] rand_value();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        return v[62:0] >> $urandom_range(0, 63);
    endfunction

    function automatic logic [39:0] rand_time();
        return {8'($urandom()), 32'($urandom())};
    endfunction

    function automatic void advance_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) gen_now = gen_now + 40'($urandom_range(0, 63));
        else if (r < 80) gen_now = gen_now + 40'($urandom_range(64, 5000));
        else if (r < 88) gen_now = gen_now - 40'($urandom_range(1, 3000));
        else if (r < 95) gen_now = gen_now;
        else gen_now = rand_time();
    endfunction

    task automatic rand_item();
        int          r;
        logic [15:0] id;
        r  = $urandom_range(0, 99);
        id = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : id_pool[$urandom_range(0, 3)];
        if (r < 4) begin
            if ($urandom_range(0, 1) == 0) gen_now = rand_time();
            send_item(shle_pkg::FUNC_START, 16'($urandom()), rand_value(), gen_now);
        end else if (r < 12) begin
            send_item(shle_pkg::FUNC_DECLARE, id, rand_value(), rand_time());
        end else if (r < 15) begin
            send_item(FUNC_UNUSED, 16'($urandom()), rand_value(), rand_time());
        end else begin
            advance_time();
            send_item(shle_pkg::FUNC_FEED, id, ($urandom_range(0, 1) == 0) ?
                      63'($urandom_range(0, 40)) : rand_value(), gen_now);
        end
    endtask

    task automatic test_start_records();
        send_item(shle_pkg::FUNC_START, 16'h0000, 63'd0, 40'd0);
        send_item(shle_pkg::FUNC_START, 16'hFFFF, {63{1'b1}}, {40{1'b1}});
        send_item(shle_pkg::FUNC_START, 16'h1234, 63'd5, 40'h80);
    endtask

    task automatic test_declare_records();
        send_item(shle_pkg::FUNC_DECLARE, 16'h0000, 63'd0, 40'd0);
        send_item(shle_pkg::FUNC_DECLARE, 16'h007F, 63'd0, 40'd0);
        send_item(shle_pkg::FUNC_DECLARE, 16'h0080, 63'd0, 40'd0);
        send_item(shle_pkg::FUNC_DECLARE, 16'h7FFF, 63'd0, 40'd0);
        send_item(shle_pkg::FUNC_DECLARE, 16'hFFFF, {63{1'b1}}, {40{1'b1}});
    endtask

    task automatic test_feed_records();
        send_item(shle_pkg::FUNC_START, 16'd0, 63'd0, 40'd1000);
        send_item(shle_pkg::FUNC_FEED, 16'hFFFF, 63'd0, 40'd1000);    // select after start
        send_item(shle_pkg::FUNC_FEED, 16'd5, 63'd30, 40'd1000);      // select, no time
        send_item(shle_pkg::FUNC_FEED, 16'd5, 63'd31, 40'd1001);      // dt 1, long value
        send_item(shle_pkg::FUNC_FEED, 16'd5, {63{1'b1}}, 40'd1064);  // dt 63, widest value
        send_item(shle_pkg::FUNC_FEED, 16'd5, 63'd7, 40'd1128);       // dt 64
        send_item(shle_pkg::FUNC_FEED, 16'd5, 63'd8, 40'd628);        // backwards
        send_item(shle_pkg::FUNC_FEED, 16'd6, 63'd9, {40{1'b1}});     // huge jump
        send_item(shle_pkg::FUNC_FEED, 16'd6, 63'd10, 40'd0);         // huge step back
        send_item(FUNC_UNUSED, 16'hFFFF, {63{1'b1}}, {40{1'b1}});
        send_item(shle_pkg::FUNC_FEED, 16'd6, 63'h40_0000_0000, 40'd5);
    endtask

    task automatic test_register_extremes();
        logic [7:0] limits[5] = '{8'd0, 8'd0, 8'd1, 8'd255, 8'd255};
        logic [8:0] counts[5] = '{9'd0, 9'd1, 9'd511, 9'd256, 9'd2};
        for (int p = 0; p < 5; p++) begin
            set_registers(limits[p], counts[p]);
            gen_now = rand_time();
            send_item(shle_pkg::FUNC_START, 16'd0, 63'd0, gen_now);
            for (int i = 0; i < 4; i++) begin
                advance_time();
                send_item(shle_pkg::FUNC_FEED, 16'($urandom_range(0, 2)), rand_value(),
                          gen_now);
            end
        end
    endtask

    // bucket index wraps from 255 to 0 with a ring longer than 256
    task automatic test_index_wrap();
        set_registers(8'd0, 9'd300);
        gen_now = rand_time();
        send_item(shle_pkg::FUNC_START, 16'd0, 63'd0, gen_now);
        for (int i = 0; i < 258; i++) begin
            advance_time();
            send_item(shle_pkg::FUNC_FEED, 16'($urandom_range(0, 3)), ($urandom_range(0, 1) == 0) ?
                      63'($urandom_range(0, 40)) : rand_value(), gen_now);
        end
    endtask

    task automatic test_random_traffic();
        logic [7:0] limit;
        logic [8:0] count;
        for (int p = 0; p < 5; p++) begin
            case ($urandom_range(0, 3))
                0: limit = 8'd0;
                1: limit = 8'd255;
                default: limit = 8'($urandom_range(1, 40));
            endcase
            case ($urandom_range(0, 4))
                0: count = 9'd0;
                1: count = 9'd1;
                2: count = 9'($urandom_range(256, 511));
                default: count = 9'($urandom_range(2, 12));
            endcase
            set_registers(limit, count);
            if (p == 4) idle_on = 1'b0;
            id_pool[0] = 16'($urandom_range(0, 3));
            id_pool[1] = 16'($urandom_range(0, 3));
            id_pool[2] = 16'($urandom());
            id_pool[3] = 16'($urandom());
            gen_now = rand_time();
            send_item(shle_pkg::FUNC_START, 16'($urandom()), rand_value(), gen_now);
            for (int i = 0; i < 6; i++) rand_item();
        end
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        item_if.valid     <= 1'b0;
        item_if.func      <= shle_pkg::FUNC_START;
        item_if.signal_id <= '0;
        item_if.value     <= '0;
        item_if.now       <= '0;
        res_if.ready      <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        watchdog          <= 0;
        idle_on       = 1'b1;
        errors        = 0;
        items_sent    = 0;
        bytes_checked = 0;
        bucket_moves  = 0;
        gen_now       = '0;
        cfg_limit     = shle_pkg::LIMIT_RESET;
        cfg_count     = shle_pkg::COUNT_RESET;
        cur_id        = '0;
        cur_valid     = 1'b0;
        last_t        = '0;
        bkt_idx       = '0;
        bkt_len       = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_start_records();
        test_declare_records();
        test_feed_records();
        test_register_extremes();
        test_index_wrap();
        test_random_traffic();

        wait_idle();
        if (log_bytes_q.size() != 0) begin
            errors++;
            $display("%0d expected bytes never arrived", log_bytes_q.size());
        end
        $display("run covered %0d items, %0d log bytes checked, %0d bucket moves",
                 items_sent, bytes_checked, bucket_moves);
        $display("%0d errors", errors);
        if (errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// File: sim.f
src/shle_pkg.sv
src/shle_if.sv
src/shle_front.sv
src/shle_fifo.sv
src/shle_back.sv
src/signal_history_log_encoder_top.sv
tb/sv/testbench.sv
